// ===== rtl/dpfd_pkg.sv =====
// Shared types, constants and register codes for the pulse frame decoder.
`timescale 1ns / 1ps

package dpfd_pkg;

    // Frame geometry.
    localparam int FRAME_BYTES = 5;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam int OUT_BYTES   = 5;
    localparam int SHOWN_BYTES = (FRAME_BYTES < OUT_BYTES) ? FRAME_BYTES : OUT_BYTES;
    localparam int BIT_CNT_W   = $clog2(FRAME_BITS + 1);

    localparam int TIME_W = 15;
    localparam int SYM_W  = 7;
    localparam logic [SYM_W-1:0] SYM_MAX = {SYM_W{1'b1}};

    // Queue between the classifier and the assembler.
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESPONSE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SYMS  = 2'd3;

    localparam logic [TIME_W-1:0] LONG_LOW_RESET = 15'd15000;
    localparam logic [TIME_W-1:0] RESPONSE_RESET = 15'd80;
    localparam logic [TIME_W-1:0] ONE_THR_RESET  = 15'd60;
    localparam logic [SYM_W-1:0]  MIN_SYMS_RESET = 7'd43;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FEW_SYMS = 2'd1,
        ST_BIT_CNT  = 2'd2,
        ST_CHECKSUM = 2'd3
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0] low_time;
        logic [TIME_W-1:0] high_time;
        logic              frame_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
    } out_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] long_low_limit;
        logic [TIME_W-1:0] response_limit;
        logic [TIME_W-1:0] one_threshold;
        logic [SYM_W-1:0]  min_symbols;
    } cfg_t;

    // One classified pulse pair.
    typedef struct packed {
        logic skip;
        logic bit_val;
        logic last;
    } sym_t;

endpackage

// ===== rtl/dpfd_classify.sv =====
// Front end: accepts pulse pairs and classifies each as skipped or as a data bit.
`timescale 1ns / 1ps

module dpfd_classify (
    input  logic              s_valid,
    output logic              s_ready,
    input  dpfd_pkg::in_item_t s_item,
    input  dpfd_pkg::cfg_t    cfg,
    input  logic              q_full,
    output logic              q_push,
    output dpfd_pkg::sym_t    q_sym
);

    logic skip;

    assign skip = (s_item.low_time >= cfg.long_low_limit)
               || (s_item.low_time >= cfg.response_limit)
               || (s_item.high_time >= cfg.response_limit);

    assign s_ready       = ~q_full;
    assign q_push        = s_valid & ~q_full;
    assign q_sym.skip    = skip;
    assign q_sym.bit_val = (s_item.high_time > cfg.one_threshold);
    assign q_sym.last    = s_item.frame_end;

endmodule

// ===== rtl/dpfd_queue.sv =====
// Short queue of classified pulse pairs between the front and back ends.
`timescale 1ns / 1ps

module dpfd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dpfd_pkg::sym_t push_sym,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output dpfd_pkg::sym_t head_sym
);

    dpfd_pkg::sym_t                   entries_reg [dpfd_pkg::QUEUE_DEPTH];
    logic [dpfd_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dpfd_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dpfd_pkg::QUEUE_AW:0]      count_reg, count_next;

    assign full      = (count_reg == (dpfd_pkg::QUEUE_AW+1)'(dpfd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_sym  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_sym;
        end
    end

endmodule

// ===== rtl/dpfd_assemble.sv =====
// Back end: shifts data bits into the frame and issues the result at frame end.
`timescale 1ns / 1ps

module dpfd_assemble (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dpfd_pkg::cfg_t       cfg,
    input  logic                 q_not_empty,
    input  dpfd_pkg::sym_t       q_sym,
    output logic                 q_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dpfd_pkg::out_item_t  m_item
);

    logic [dpfd_pkg::FRAME_BITS-1:0] frame_bits_reg, frame_bits_next;
    logic [dpfd_pkg::BIT_CNT_W-1:0]  bit_count_reg, bit_count_next;
    logic [dpfd_pkg::SYM_W-1:0]      sym_count_reg, sym_count_next;
    logic                            m_valid_reg, m_valid_next;
    dpfd_pkg::out_item_t             m_item_reg;
    dpfd_pkg::out_item_t             result;

    logic                            out_free;
    logic                            emit;
    logic [7:0]                      fbytes [dpfd_pkg::FRAME_BYTES];
    logic [7:0]                      obytes [dpfd_pkg::OUT_BYTES];
    logic [7:0]                      csum;
    dpfd_pkg::status_t               status;

    // A result-free pair never needs the output register.
    assign out_free = ~m_valid_reg | m_ready;
    assign q_pop    = q_not_empty & (~q_sym.last | out_free);
    assign emit     = q_pop & q_sym.last;

    always_comb begin
        sym_count_next  = sym_count_reg;
        frame_bits_next = frame_bits_reg;
        bit_count_next  = bit_count_reg;
        if (sym_count_reg != dpfd_pkg::SYM_MAX) begin
            sym_count_next = sym_count_reg + 1'b1;
        end
        if (!q_sym.skip
            && (bit_count_reg < dpfd_pkg::BIT_CNT_W'(dpfd_pkg::FRAME_BITS))) begin
            frame_bits_next = {frame_bits_reg[dpfd_pkg::FRAME_BITS-2:0], q_sym.bit_val};
            bit_count_next  = bit_count_reg + 1'b1;
        end
    end

    // Frame checks run on the state as it stands after the final pair.
    always_comb begin
        for (int k = 0; k < dpfd_pkg::FRAME_BYTES; k++) begin
            fbytes[k] = frame_bits_next[dpfd_pkg::FRAME_BITS-1-8*k -: 8];
        end
        csum = '0;
        for (int k = 0; k < dpfd_pkg::FRAME_BYTES - 1; k++) begin
            csum = csum + fbytes[k];
        end
        if (sym_count_next < cfg.min_symbols) begin
            status = dpfd_pkg::ST_FEW_SYMS;
        end else if (bit_count_next != dpfd_pkg::BIT_CNT_W'(dpfd_pkg::FRAME_BITS)) begin
            status = dpfd_pkg::ST_BIT_CNT;
        end else if (csum != fbytes[dpfd_pkg::FRAME_BYTES-1]) begin
            status = dpfd_pkg::ST_CHECKSUM;
        end else begin
            status = dpfd_pkg::ST_OK;
        end
        for (int k = 0; k < dpfd_pkg::OUT_BYTES; k++) begin
            obytes[k] = '0;
        end
        if (status == dpfd_pkg::ST_OK) begin
            for (int k = 0; k < dpfd_pkg::SHOWN_BYTES; k++) begin
                obytes[k] = fbytes[k];
            end
        end
        result.status     = status;
        result.byte_zero  = obytes[0];
        result.byte_one   = obytes[1];
        result.byte_two   = obytes[2];
        result.byte_three = obytes[3];
        result.byte_four  = obytes[4];
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bits_reg <= '0;
            bit_count_reg  <= '0;
            sym_count_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                if (q_sym.last) begin
                    frame_bits_reg <= '0;
                    bit_count_reg  <= '0;
                    sym_count_reg  <= '0;
                end else begin
                    frame_bits_reg <= frame_bits_next;
                    bit_count_reg  <= bit_count_next;
                    sym_count_reg  <= sym_count_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ===== rtl/dht_pulse_frame_decoder_core.sv =====
// Top level of the pulse frame decoder: configuration registers and block wiring.
//
//  Port group  Direction  Handshake         Carries
//  s_*         in         s_valid/s_ready   one pulse pair (low, high, frame end)
//  m_*         out        m_valid/m_ready   frame status and five bytes
//  cfg_*       in         cfg_we only       limits, threshold, minimum pair count
//
// One pulse pair is accepted per cycle while the queue has room; the back end retires
// one per cycle unless a frame-end pair waits on the result register. Each queued pair
// is applied to the frame state as it pops, and a frame-end pair's result is registered
// as it pops; the result register frees when taken. A stalled result holds only a
// frame-end pair at the queue head; one more pair fills its other entry and s_ready drops.
// Reset is synchronous; registers return to their defaults and the frame clears.
`timescale 1ns / 1ps

module dht_pulse_frame_decoder_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [dpfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dpfd_pkg::TIME_W-1:0]           cfg_data,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  dpfd_pkg::in_item_t                    s_item,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output dpfd_pkg::out_item_t                   m_item
);

    dpfd_pkg::cfg_t  cfg_reg;
    logic            q_full;
    logic            q_push;
    dpfd_pkg::sym_t  q_in_sym;
    logic            q_pop;
    logic            q_not_empty;
    dpfd_pkg::sym_t  q_head_sym;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.long_low_limit <= dpfd_pkg::LONG_LOW_RESET;
            cfg_reg.response_limit <= dpfd_pkg::RESPONSE_RESET;
            cfg_reg.one_threshold  <= dpfd_pkg::ONE_THR_RESET;
            cfg_reg.min_symbols    <= dpfd_pkg::MIN_SYMS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                dpfd_pkg::CFG_LONG_LOW: cfg_reg.long_low_limit <= cfg_data;
                dpfd_pkg::CFG_RESPONSE: cfg_reg.response_limit <= cfg_data;
                dpfd_pkg::CFG_ONE_THR:  cfg_reg.one_threshold  <= cfg_data;
                dpfd_pkg::CFG_MIN_SYMS: cfg_reg.min_symbols    <= cfg_data[dpfd_pkg::SYM_W-1:0];
                default: ;
            endcase
        end
    end

    dpfd_classify u_classify (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .cfg     (cfg_reg),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_sym   (q_in_sym)
    );

    dpfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_sym  (q_in_sym),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_sym  (q_head_sym)
    );

    dpfd_assemble u_assemble (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_sym       (q_head_sym),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

// ===== tb/dht_pulse_frame_decoder_core_tb.sv =====
// Self-checking testbench for the pulse frame decoder core with a built-in frame predictor.
`timescale 1ns / 1ps

module dht_pulse_frame_decoder_core_tb;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_SHORT_BITS,
        FR_EXTRA_BITS,
        FR_LONG,
        FR_NOISE
    } frame_kind_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [dpfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dpfd_pkg::TIME_W-1:0]    cfg_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    dpfd_pkg::in_item_t             s_item = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    dpfd_pkg::out_item_t            m_item;

    // Predictor copy of the registers and the frame being assembled.
    logic [dpfd_pkg::TIME_W-1:0]     p_long_low = dpfd_pkg::LONG_LOW_RESET;
    logic [dpfd_pkg::TIME_W-1:0]     p_response = dpfd_pkg::RESPONSE_RESET;
    logic [dpfd_pkg::TIME_W-1:0]     p_one_thr = dpfd_pkg::ONE_THR_RESET;
    logic [dpfd_pkg::SYM_W-1:0]      p_min_syms = dpfd_pkg::MIN_SYMS_RESET;
    logic [dpfd_pkg::FRAME_BITS-1:0] shift_bits = '0;
    int                              bits_seen = 0;
    int                              pairs_seen = 0;

    dpfd_pkg::in_item_t  pair_q[$];
    dpfd_pkg::out_item_t decoded_q[$];
    dpfd_pkg::out_item_t front_frame;

    int queued = 0;
    int accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int settings_used = 0;
    int status_hist[4] = '{0, 0, 0, 0};
    int burst_left = 0;
    int gap_left = 0;
    int rx_mode = 0;
    int rx_left = 0;

    dht_pulse_frame_decoder_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Applies one accepted pulse pair to the predicted frame state.
    task automatic decode_pair(input dpfd_pkg::in_item_t p);
        logic [7:0]         fb[dpfd_pkg::FRAME_BYTES];
        logic [7:0]         shown[dpfd_pkg::OUT_BYTES];
        logic [7:0]         sum;
        dpfd_pkg::status_t  st;
        if (pairs_seen < dpfd_pkg::SYM_MAX) pairs_seen++;
        if (!(p.low_time >= p_long_low || p.low_time >= p_response ||
              p.high_time >= p_response) && bits_seen < dpfd_pkg::FRAME_BITS) begin
            shift_bits = {shift_bits[dpfd_pkg::FRAME_BITS-2:0], p.high_time > p_one_thr};
            bits_seen++;
        end
        if (!p.frame_end) return;
        sum = '0;
        for (int k = 0; k < dpfd_pkg::FRAME_BYTES; k++) begin
            fb[k] = shift_bits[dpfd_pkg::FRAME_BITS-1-8*k -: 8];
            if (k < dpfd_pkg::FRAME_BYTES - 1) sum += fb[k];
        end
        // Error priority: pair count, then bit count, then checksum.
        if (pairs_seen < p_min_syms) st = dpfd_pkg::ST_FEW_SYMS;
        else if (bits_seen != dpfd_pkg::FRAME_BITS) st = dpfd_pkg::ST_BIT_CNT;
        else if (sum != fb[dpfd_pkg::FRAME_BYTES-1]) st = dpfd_pkg::ST_CHECKSUM;
        else st = dpfd_pkg::ST_OK;
        for (int k = 0; k < dpfd_pkg::OUT_BYTES; k++) begin
            shown[k] = (st == dpfd_pkg::ST_OK && k < dpfd_pkg::FRAME_BYTES) ? fb[k] : 8'h00;
        end
        decoded_q.push_back('{st, shown[0], shown[1], shown[2], shown[3], shown[4]});
        shift_bits = '0;
        bits_seen = 0;
        pairs_seen = 0;
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_pair(s_item);
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pair_q.size() > 0) begin
                    s_item <= pair_q.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Receiver: checks each frame result and stalls on a pattern of its own.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                status_hist[m_item.status]++;
                if (decoded_q.size() == 0) begin
                    $error("frame result with none pending: status %0d", m_item.status);
                    mismatches++;
                end else begin
                    front_frame = decoded_q.pop_front();
                    compare_field("status", front_frame.status, m_item.status);
                    compare_field("byte_zero", front_frame.byte_zero, m_item.byte_zero);
                    compare_field("byte_one", front_frame.byte_one, m_item.byte_one);
                    compare_field("byte_two", front_frame.byte_two, m_item.byte_two);
                    compare_field("byte_three", front_frame.byte_three, m_item.byte_three);
                    compare_field("byte_four", front_frame.byte_four, m_item.byte_four);
                end
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(10, 200);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic queue_pair(input int lo, input int hi, input bit fe);
        dpfd_pkg::in_item_t p;
        p.low_time = lo[dpfd_pkg::TIME_W-1:0];
        p.high_time = hi[dpfd_pkg::TIME_W-1:0];
        p.frame_end = fe;
        pair_q.push_back(p);
        queued++;
    endtask

    // A pair that decodes as the given bit under the current settings, where possible.
    task automatic queue_data_bit(input bit b, input bit fe);
        int ll, rsp, thr, lim, lo, hi, top;
        ll = p_long_low;
        rsp = p_response;
        thr = p_one_thr;
        lim = (ll < rsp) ? ll : rsp;
        if (lim == 0) lo = $urandom_range(0, 32767);
        else if ($urandom_range(0, 7) == 0) lo = lim - 1;
        else lo = $urandom_range(0, lim - 1);
        if (b) begin
            if (thr + 1 < rsp)
                hi = ($urandom_range(0, 7) == 0) ? thr + 1 : $urandom_range(thr + 1, rsp - 1);
            else
                hi = $urandom_range(0, 32767);
        end else begin
            top = (thr < rsp) ? thr : rsp - 1;
            if (top < 0) hi = $urandom_range(0, 32767);
            else hi = ($urandom_range(0, 7) == 0) ? top : $urandom_range(0, top);
        end
        queue_pair(lo, hi, fe);
    endtask

    // A pair the decoder must skip: host start pulse or sensor response pulse.
    task automatic queue_skip_pair(input bit fe);
        int ll, rsp;
        ll = p_long_low;
        rsp = p_response;
        case ($urandom_range(0, 2))
            0: queue_pair($urandom_range(ll, 32767), $urandom_range(0, 32767), fe);
            1: queue_pair($urandom_range(rsp, 32767), $urandom_range(0, 32767), fe);
            default: queue_pair($urandom_range(0, 32767), $urandom_range(rsp, 32767), fe);
        endcase
    endtask

    task automatic queue_frame(input frame_kind_t kind);
        logic [7:0] fb[dpfd_pkg::FRAME_BYTES];
        logic [7:0] sum;
        int         nbits, n;
        bit         b, end_on_skip;
        if (kind == FR_NOISE) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
                queue_pair(($urandom_range(0, 2) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 32767),
                           ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(0, 32767),
                           i == n - 1);
            end
            return;
        end
        sum = '0;
        for (int i = 0; i < dpfd_pkg::FRAME_BYTES - 1; i++) begin
            case ($urandom_range(0, 7))
                0: fb[i] = 8'h00;
                1: fb[i] = 8'hFF;
                default: fb[i] = 8'($urandom);
            endcase
            sum += fb[i];
        end
        fb[dpfd_pkg::FRAME_BYTES-1] = sum;
        if (kind == FR_BAD_SUM) begin
            fb[dpfd_pkg::FRAME_BYTES-1] = sum ^ 8'($urandom_range(1, 255));
        end
        nbits = dpfd_pkg::FRAME_BITS;
        if (kind == FR_SHORT_BITS) nbits = $urandom_range(0, dpfd_pkg::FRAME_BITS - 1);
        else if (kind == FR_EXTRA_BITS) nbits = dpfd_pkg::FRAME_BITS + $urandom_range(1, 8);
        end_on_skip = (nbits == 0) || ($urandom_range(0, 7) == 0);
        queue_skip_pair(1'b0);
        queue_skip_pair(1'b0);
        for (int i = 0; i < nbits; i++) begin
            // Long frames carry extra skipped pairs, usually enough to push the pair count past saturation.
            n = (kind == FR_LONG) ? $urandom_range(0, 5) : ($urandom_range(0, 15) == 0);
            repeat (n) queue_skip_pair(1'b0);
            b = (i < dpfd_pkg::FRAME_BITS) ? fb[i/8][7 - i%8] : $urandom_range(0, 1);
            queue_data_bit(b, !end_on_skip && i == nbits - 1);
        end
        if (end_on_skip) queue_skip_pair(1'b1);
    endtask

    // Returns once every queued item is taken, every frame result is back and
    // the pairs still inside the block have drained.
    task automatic settle();
        while (accepted != queued || decoded_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_config(input int ll, input int rsp, input int thr, input int ms);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= dpfd_pkg::CFG_LONG_LOW;
        cfg_data <= ll[dpfd_pkg::TIME_W-1:0];
        @(posedge aclk);
        cfg_index <= dpfd_pkg::CFG_RESPONSE;
        cfg_data <= rsp[dpfd_pkg::TIME_W-1:0];
        @(posedge aclk);
        cfg_index <= dpfd_pkg::CFG_ONE_THR;
        cfg_data <= thr[dpfd_pkg::TIME_W-1:0];
        @(posedge aclk);
        // Upper data bits are junk; only the low seven reach the register.
        cfg_index <= dpfd_pkg::CFG_MIN_SYMS;
        cfg_data <= {8'($urandom_range(0, 255)), ms[dpfd_pkg::SYM_W-1:0]};
        @(posedge aclk);
        cfg_we <= 1'b0;
        p_long_low = ll[dpfd_pkg::TIME_W-1:0];
        p_response = rsp[dpfd_pkg::TIME_W-1:0];
        p_one_thr = thr[dpfd_pkg::TIME_W-1:0];
        p_min_syms = ms[dpfd_pkg::SYM_W-1:0];
        settings_used++;
    endtask

    task automatic run_random(input int target);
        int          start, r;
        frame_kind_t kind;
        start = queued;
        while (queued - start < target) begin
            r = $urandom_range(0, 99);
            if (r < 45) kind = FR_GOOD;
            else if (r < 60) kind = FR_BAD_SUM;
            else if (r < 70) kind = FR_SHORT_BITS;
            else if (r < 80) kind = FR_EXTRA_BITS;
            else if (r < 88) kind = FR_LONG;
            else kind = FR_NOISE;
            queue_frame(kind);
        end
        settle();
    endtask

    initial begin
        int rsp;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Default settings: field extremes and limit edges; a lone end pair
        // reports too few pairs ahead of any bit count problem.
        queue_pair(0, 0, 1'b1);
        queue_pair(32767, 32767, 1'b0);
        queue_pair(0, 32767, 1'b0);
        queue_pair(79, 79, 1'b0);
        queue_pair(80, 0, 1'b0);
        queue_pair(0, 80, 1'b0);
        queue_pair(0, 60, 1'b0);
        queue_pair(0, 61, 1'b1);
        settle();

        // With no pair minimum a short frame fails on its bit count.
        set_config(100, 32767, 0, 0);
        queue_pair(99, 1, 1'b0);
        queue_pair(100, 0, 1'b0);
        queue_pair(0, 0, 1'b0);
        queue_pair(0, 32766, 1'b0);
        queue_pair(0, 32767, 1'b1);
        settle();

        // A zero response limit skips everything.
        set_config(32767, 0, 32767, 127);
        queue_pair(0, 0, 1'b1);
        queue_pair(32767, 0, 1'b1);
        settle();

        set_config(15000, 80, 60, 43);
        run_random(135);
        set_config(32767, 200, 100, 127);
        run_random(150);
        set_config(0, 80, 60, 0);
        run_random(45);
        set_config(40, 32767, 20, 42);
        run_random(135);
        set_config(32767, 32767, 32767, 43);
        run_random(45);
        set_config(15000, 80, 0, 1);
        run_random(110);
        rsp = $urandom_range(20, 2000);
        set_config($urandom_range(100, 32767), rsp, $urandom_range(0, rsp - 2),
                   $urandom_range(0, 60));
        run_random(135);
        set_config(15000, 80, 60, 43);
        run_random(110);

        repeat (20) @(posedge aclk);
        if (decoded_q.size() != 0) begin
            $error("%0d frame results never arrived", decoded_q.size());
            mismatches++;
        end
        $display("Run covered %0d pulse pairs under %0d register settings, %0d frame results.",
                 accepted, settings_used + 1, results_seen);
        $display("Status mix: ok %0d, too few pairs %0d, bad bit count %0d, bad checksum %0d.",
                 status_hist[dpfd_pkg::ST_OK], status_hist[dpfd_pkg::ST_FEW_SYMS],
                 status_hist[dpfd_pkg::ST_BIT_CNT], status_hist[dpfd_pkg::ST_CHECKSUM]);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dpfd_pkg.sv
rtl/dpfd_classify.sv
rtl/dpfd_queue.sv
rtl/dpfd_assemble.sv
rtl/dht_pulse_frame_decoder_core.sv
tb/dht_pulse_frame_decoder_core_tb.sv
